### rtl/core/bpr_pkg.sv
// shared types, constants and helpers for the bmp pixel to rgb565 unit
`timescale 1ns / 1ps

package bpr_pkg;

    // default sizes
    localparam int PALETTE_BITS_DEF = 8;
    localparam int MAX_WIDTH_DEF    = 4096;

    // register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [REG_IDX_W-1:0] REG_DEPTH_MODE  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ALREADY_565 = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_SHOWN_WIDTH = 2'd3;

    localparam int CFG_WIDTH_W = 13;

    // register reset values
    localparam logic [2:0]             DEPTH_MODE_RST  = 3'd4;
    localparam logic                   ALREADY_565_RST = 1'b0;
    localparam logic [CFG_WIDTH_W-1:0] IMAGE_WIDTH_RST = 13'd320;
    localparam logic [CFG_WIDTH_W-1:0] SHOWN_WIDTH_RST = 13'd320;

    // pixel depth, modes above 16bpp all behave as 24bpp
    typedef enum logic [2:0] {
        DEPTH_1  = 3'd0,
        DEPTH_4  = 3'd1,
        DEPTH_8  = 3'd2,
        DEPTH_16 = 3'd3,
        DEPTH_24 = 3'd4
    } t_depth;

    typedef struct packed {
        t_depth depth;
        logic   is565;
    } t_mode;

    // one word handed from the byte decoder to the pixel serializer
    typedef struct packed {
        logic        is_write;   // palette entry write, no pixels
        logic [7:0]  addr;
        logic [15:0] wdata;
        logic        is_pal;     // pixels come from the palette
        t_depth      depth;
        logic [7:0]  data;       // raw byte holding palette indexes
        logic [15:0] color;      // direct color for 16/24bpp
        logic [2:0]  last_k;     // index of the final pixel slot
        logic        row_end;    // final slot closes the shown row
    } t_grp;

    function automatic t_depth f_depth(input logic [2:0] raw);
        t_depth d;
        case (raw)
            3'd0: d = DEPTH_1;
            3'd1: d = DEPTH_4;
            3'd2: d = DEPTH_8;
            3'd3: d = DEPTH_16;
            default: d = DEPTH_24;
        endcase
        return d;
    endfunction

    // blue low byte, green middle, red high
    function automatic logic [15:0] f_bgr_to_565(input logic [23:0] p);
        return {p[23:19], p[15:10], p[7:3]};
    endfunction

endpackage

### rtl/core/bpr_if.sv
// input and output channel interfaces of the bmp pixel to rgb565 unit
`timescale 1ns / 1ps

interface bpr_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  palette_index;
    logic [23:0] palette_word;
    logic [7:0]  data_byte;

    modport source(output valid, output action, output palette_index,
                   output palette_word, output data_byte, input ready);
    modport sink(input valid, input action, input palette_index,
                 input palette_word, input data_byte, output ready);
endinterface

interface bpr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_color;
    logic        row_end;
    logic        last;

    modport source(output valid, output pixel_color, output row_end,
                   output last, input ready);
    modport sink(input valid, input pixel_color, input row_end,
                 input last, output ready);
endinterface

### rtl/core/bpr_cfg.sv
// register file with derived row geometry
`timescale 1ns / 1ps

module bpr_cfg import bpr_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int COL_W     = 13,
    parameter int ROWB_W    = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_mode                 o_mode,
    output logic [COL_W-1:0]      o_iw,
    output logic [COL_W-1:0]      o_shown,
    output logic [ROWB_W-1:0]     o_data_bytes,
    output logic [ROWB_W-1:0]     o_row_size,
    output logic                  o_restart
);

    localparam int WIDE_W = (ROWB_W + 5 > 14) ? ROWB_W + 5 : 14;

    function automatic logic [COL_W-1:0] f_eff_width(input logic [CFG_WIDTH_W-1:0] raw);
        logic [COL_W-1:0] w;
        if (raw == '0) begin
            w = COL_W'(1);
        end else if (WIDE_W'(raw) > WIDE_W'(MAX_WIDTH)) begin
            w = COL_W'(MAX_WIDTH);
        end else begin
            w = COL_W'(raw);
        end
        return w;
    endfunction

    function automatic logic [COL_W-1:0] f_shown(input logic [CFG_WIDTH_W-1:0] raw,
                                                 input logic [COL_W-1:0] iw);
        return (WIDE_W'(raw) < WIDE_W'(iw)) ? COL_W'(raw) : iw;
    endfunction

    // ceil(width * bpp / 8)
    function automatic logic [ROWB_W-1:0] f_data_bytes(input t_depth d,
                                                       input logic [COL_W-1:0] iw);
        logic [WIDE_W-1:0] w;
        logic [WIDE_W-1:0] bits;
        w = WIDE_W'(iw);
        case (d)
            DEPTH_1:  bits = w;
            DEPTH_4:  bits = w << 2;
            DEPTH_8:  bits = w << 3;
            DEPTH_16: bits = w << 4;
            default:  bits = (w << 4) + (w << 3);
        endcase
        return ROWB_W'((bits + WIDE_W'(7)) >> 3);
    endfunction

    // padded to four bytes
    function automatic logic [ROWB_W-1:0] f_row_size(input logic [ROWB_W-1:0] db);
        return (db + ROWB_W'(3)) & ~ROWB_W'(3);
    endfunction

    logic [2:0]             r_depth_raw, n_depth_raw;
    logic                   r_is565, n_is565;
    logic [CFG_WIDTH_W-1:0] r_iw_raw, n_iw_raw;
    logic [CFG_WIDTH_W-1:0] r_sw_raw, n_sw_raw;
    t_depth                 r_depth, n_depth;
    logic [COL_W-1:0]       r_iw, n_iw;
    logic [COL_W-1:0]       r_shown, n_shown;
    logic [ROWB_W-1:0]      r_db, n_db;
    logic [ROWB_W-1:0]      r_rs, n_rs;
    logic                   wr;

    assign wr = psel && penable && pwrite;

    always_comb begin
        n_depth_raw = r_depth_raw;
        n_is565     = r_is565;
        n_iw_raw    = r_iw_raw;
        n_sw_raw    = r_sw_raw;
        if (wr) begin
            case (paddr[3:2])
                REG_DEPTH_MODE:  n_depth_raw = pwdata[2:0];
                REG_ALREADY_565: n_is565     = pwdata[0];
                REG_IMAGE_WIDTH: n_iw_raw    = pwdata[CFG_WIDTH_W-1:0];
                REG_SHOWN_WIDTH: n_sw_raw    = pwdata[CFG_WIDTH_W-1:0];
                default: begin
                end
            endcase
        end
        n_depth = f_depth(n_depth_raw);
        n_iw    = f_eff_width(n_iw_raw);
        n_shown = f_shown(n_sw_raw, n_iw);
        n_db    = f_data_bytes(n_depth, n_iw);
        n_rs    = f_row_size(n_db);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_raw <= DEPTH_MODE_RST;
            r_is565     <= ALREADY_565_RST;
            r_iw_raw    <= IMAGE_WIDTH_RST;
            r_sw_raw    <= SHOWN_WIDTH_RST;
            r_depth     <= f_depth(DEPTH_MODE_RST);
            r_iw        <= f_eff_width(IMAGE_WIDTH_RST);
            r_shown     <= f_shown(SHOWN_WIDTH_RST, f_eff_width(IMAGE_WIDTH_RST));
            r_db        <= f_data_bytes(f_depth(DEPTH_MODE_RST),
                                        f_eff_width(IMAGE_WIDTH_RST));
            r_rs        <= f_row_size(f_data_bytes(f_depth(DEPTH_MODE_RST),
                                                   f_eff_width(IMAGE_WIDTH_RST)));
        end else begin
            r_depth_raw <= n_depth_raw;
            r_is565     <= n_is565;
            r_iw_raw    <= n_iw_raw;
            r_sw_raw    <= n_sw_raw;
            r_depth     <= n_depth;
            r_iw        <= n_iw;
            r_shown     <= n_shown;
            r_db        <= n_db;
            r_rs        <= n_rs;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DEPTH_MODE:  prdata = APB_DATA_W'(r_depth_raw);
            REG_ALREADY_565: prdata = APB_DATA_W'(r_is565);
            REG_IMAGE_WIDTH: prdata = APB_DATA_W'(r_iw_raw);
            REG_SHOWN_WIDTH: prdata = APB_DATA_W'(r_sw_raw);
            default:         prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign o_mode       = '{depth: r_depth, is565: r_is565};
    assign o_iw         = r_iw;
    assign o_shown      = r_shown;
    assign o_data_bytes = r_db;
    assign o_row_size   = r_rs;
    // every register write restarts the row
    assign o_restart    = wr;

endmodule

### rtl/core/bpr_decode.sv
// byte decoder: row position, byte assembly and the pixel word register
`timescale 1ns / 1ps

module bpr_decode import bpr_pkg::*; #(
    parameter int COL_W  = 13,
    parameter int ROWB_W = 14
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bpr_in_if.sink            in_w,
    input  t_mode             i_mode,
    input  logic [COL_W-1:0]  i_iw,
    input  logic [COL_W-1:0]  i_shown,
    input  logic [ROWB_W-1:0] i_data_bytes,
    input  logic [ROWB_W-1:0] i_row_size,
    input  logic              i_restart,
    output t_grp              o_grp,
    output logic              o_grp_valid,
    input  logic              i_grp_done
);

    logic [COL_W-1:0]  r_col, n_col;
    logic [ROWB_W-1:0] r_cnt, n_cnt;
    logic [1:0]        r_phase, n_phase;
    logic [15:0]       r_held, n_held;
    logic              r_gv;
    t_grp              r_grp, n_grp;

    logic              take;
    logic              in_data;
    logic              is_pal;
    logic [3:0]        per_byte;
    logic [COL_W-1:0]  per_ext;
    logic [COL_W-1:0]  avail;
    logic [COL_W-1:0]  left;
    logic [COL_W-1:0]  cons;
    logic [COL_W-1:0]  emit;
    logic [15:0]       color;
    logic              grp_load;

    assign in_w.ready = !r_gv || i_grp_done;
    assign take       = in_w.valid && in_w.ready;
    assign in_data    = r_cnt < i_data_bytes;
    assign is_pal     = (i_mode.depth == DEPTH_1) || (i_mode.depth == DEPTH_4)
                        || (i_mode.depth == DEPTH_8);

    always_comb begin
        // pixels finished by this byte
        case (i_mode.depth)
            DEPTH_1:  per_byte = 4'd8;
            DEPTH_4:  per_byte = 4'd2;
            DEPTH_8:  per_byte = 4'd1;
            DEPTH_16: per_byte = (r_phase == 2'd1) ? 4'd1 : 4'd0;
            default:  per_byte = (r_phase == 2'd2) ? 4'd1 : 4'd0;
        endcase
        if (!in_data) begin
            per_byte = 4'd0;
        end
        per_ext = COL_W'(per_byte);
        avail   = i_iw - r_col;
        left    = (i_shown > r_col) ? i_shown - r_col : '0;
        cons    = (avail < per_ext) ? avail : per_ext;
        emit    = (left < per_ext) ? left : per_ext;

        if (i_mode.depth == DEPTH_16) begin
            if (i_mode.is565) begin
                color = {in_w.data_byte, r_held[7:0]};
            end else begin
                // 555 widened, top bit dropped
                color = {in_w.data_byte[6:0], r_held[7:5], 1'b0, r_held[4:0]};
            end
        end else begin
            color = {in_w.data_byte[7:3], r_held[15:10], r_held[7:3]};
        end

        n_grp.is_write = !in_w.action;
        n_grp.addr     = in_w.palette_index;
        n_grp.wdata    = f_bgr_to_565(in_w.palette_word);
        n_grp.is_pal   = is_pal;
        n_grp.depth    = i_mode.depth;
        n_grp.data     = in_w.data_byte;
        n_grp.color    = color;
        n_grp.last_k   = 3'(emit - COL_W'(1));
        n_grp.row_end  = (emit != '0) && (left <= per_ext);

        grp_load = take && (!in_w.action || (emit != '0));

        n_col   = r_col;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        n_held  = r_held;
        if (take && in_w.action) begin
            n_col = r_col + cons;
            if (in_data && !is_pal) begin
                case (r_phase)
                    2'd0: begin
                        n_held  = {8'h00, in_w.data_byte};
                        n_phase = 2'd1;
                    end
                    2'd1: begin
                        if (i_mode.depth == DEPTH_16) begin
                            n_held  = '0;
                            n_phase = 2'd0;
                        end else begin
                            n_held  = {in_w.data_byte, r_held[7:0]};
                            n_phase = 2'd2;
                        end
                    end
                    default: begin
                        n_held  = '0;
                        n_phase = 2'd0;
                    end
                endcase
            end
            n_cnt = r_cnt + ROWB_W'(1);
            if (n_cnt >= i_row_size) begin
                n_col   = '0;
                n_cnt   = '0;
                n_phase = 2'd0;
                n_held  = '0;
            end
        end
        if (i_restart) begin
            n_col   = '0;
            n_cnt   = '0;
            n_phase = 2'd0;
            n_held  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_cnt   <= '0;
            r_phase <= 2'd0;
            r_held  <= '0;
            r_gv    <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_cnt   <= n_cnt;
            r_phase <= n_phase;
            r_held  <= n_held;
            if (in_w.ready) begin
                r_gv <= grp_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (grp_load) begin
            r_grp <= n_grp;
        end
    end

    assign o_grp       = r_grp;
    assign o_grp_valid = r_gv;

endmodule

### rtl/core/bpr_serial.sv
// pixel serializer with palette memory and output register
`timescale 1ns / 1ps

module bpr_serial import bpr_pkg::*; #(
    parameter int PALETTE_BITS = PALETTE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_grp      i_grp,
    input  logic      i_grp_valid,
    output logic      o_grp_done,
    bpr_out_if.source out_w
);

    localparam int PAL_DEPTH = 1 << PALETTE_BITS;

    logic [15:0] palette_mem [PAL_DEPTH];

    logic [2:0]  r_k;
    logic        r_ov;
    logic        r_use_pal;
    logic [15:0] r_direct;
    logic [15:0] r_q;
    logic        r_row_end;
    logic        r_last;

    logic        out_load;
    logic        pix_go;
    logic        last_slot;
    logic [7:0]  idx8;

    assign out_load   = !r_ov || out_w.ready;
    assign pix_go     = i_grp_valid && !i_grp.is_write && out_load;
    assign last_slot  = r_k == i_grp.last_k;
    assign o_grp_done = i_grp_valid && (i_grp.is_write || (out_load && last_slot));

    // palette index of slot k, most significant bits first
    always_comb begin
        case (i_grp.depth)
            DEPTH_1: idx8 = {7'd0, i_grp.data[3'd7 - r_k]};
            DEPTH_4: idx8 = {4'd0, r_k[0] ? i_grp.data[3:0] : i_grp.data[7:4]};
            default: idx8 = i_grp.data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_grp_valid && i_grp.is_write) begin
            palette_mem[i_grp.addr[PALETTE_BITS-1:0]] <= i_grp.wdata;
        end
        if (pix_go) begin
            r_q <= palette_mem[idx8[PALETTE_BITS-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= 3'd0;
            r_ov <= 1'b0;
        end else begin
            if (pix_go) begin
                r_k <= last_slot ? 3'd0 : r_k + 3'd1;
            end
            if (out_load) begin
                r_ov <= pix_go;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_go) begin
            r_use_pal <= i_grp.is_pal;
            r_direct  <= i_grp.color;
            r_row_end <= i_grp.row_end && last_slot;
            r_last    <= last_slot;
        end
    end

    assign out_w.valid       = r_ov;
    assign out_w.pixel_color = r_use_pal ? r_q : r_direct;
    assign out_w.row_end     = r_row_end;
    assign out_w.last        = r_last;

endmodule

### rtl/core/bmp_pixel_to_rgb565_unit.sv
// top level of the bmp pixel to rgb565 unit
// path: a byte loads the decode word register, its pixels the output register
// throughput: one byte per cycle while each byte gives at most one pixel and the
//   output is not stalled; a palette byte giving up to 8 pixels holds the word
//   register until its last pixel is sent, as the output carries one pixel per word
// reset: synchronous active-low i_rst_n restores register defaults and row state;
//   palette contents are undefined until written
`timescale 1ns / 1ps

module bmp_pixel_to_rgb565_unit import bpr_pkg::*; #(
    parameter int PALETTE_BITS = PALETTE_BITS_DEF,
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bpr_in_if.sink                i_pix_in,
    bpr_out_if.source             o_pix_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // column counter holds the full width, row counter the padded row size
    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROWB_W = $clog2(MAX_WIDTH * 3 + 4);

    t_mode             w_mode;
    logic [COL_W-1:0]  w_iw;
    logic [COL_W-1:0]  w_shown;
    logic [ROWB_W-1:0] w_data_bytes;
    logic [ROWB_W-1:0] w_row_size;
    logic              w_restart;
    t_grp              w_grp;
    logic              w_grp_valid;
    logic              w_grp_done;

    // registers plus derived geometry: clamped widths, data bytes and padded row size
    bpr_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W),
        .ROWB_W    (ROWB_W)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_mode       (w_mode),
        .o_iw         (w_iw),
        .o_shown      (w_shown),
        .o_data_bytes (w_data_bytes),
        .o_row_size   (w_row_size),
        .o_restart    (w_restart)
    );

    // first stage: tracks position in the row, assembles 16/24bpp pixels,
    // counts shown pixels per byte and loads one word into its register
    bpr_decode #(
        .COL_W  (COL_W),
        .ROWB_W (ROWB_W)
    ) u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_w         (i_pix_in),
        .i_mode       (w_mode),
        .i_iw         (w_iw),
        .i_shown      (w_shown),
        .i_data_bytes (w_data_bytes),
        .i_row_size   (w_row_size),
        .i_restart    (w_restart),
        .o_grp        (w_grp),
        .o_grp_valid  (w_grp_valid),
        .i_grp_done   (w_grp_done)
    );

    // second stage: walks the word's pixel slots, one per cycle unless output stalls,
    // reads the palette and fills the output register; palette writes land here in order
    bpr_serial #(
        .PALETTE_BITS (PALETTE_BITS)
    ) u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp       (w_grp),
        .i_grp_valid (w_grp_valid),
        .o_grp_done  (w_grp_done),
        .out_w       (o_pix_out)
    );

`ifndef SYNTHESIS
    // the row closes on the final pixel of its byte
    a_row_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix_out.valid && o_pix_out.row_end |-> o_pix_out.last)
        else $error("row end without last");

    // an empty word register always takes a new byte
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_grp_valid |-> i_pix_in.ready)
        else $error("input stalled with empty word register");

    // palette writes retire whenever they are present
    a_pal_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_grp_valid && w_grp.is_write |-> w_grp_done)
        else $error("palette write held");

    // a word is only done while it is present
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_grp_done |-> w_grp_valid)
        else $error("word done without word");
`endif

endmodule
